// ===== rtl/aes128_block_encrypt_decrypt_top_defines.svh =====
// Assertion helpers for the AES-128 block.
`ifndef AES128_BLOCK_ENCRYPT_DECRYPT_TOP_DEFINES_SVH
`define AES128_BLOCK_ENCRYPT_DECRYPT_TOP_DEFINES_SVH

// Implication that holds outside reset.
`define AES_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication outside reset.
`define AES_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== rtl/aes_pkg.sv =====
`default_nettype none
package aes_pkg;

  localparam int unsigned NumRounds = 10;
  localparam int unsigned NumStages = 2 * NumRounds + 1;
  // cycles for a new key to reach the last round key register
  localparam int unsigned KeySettle = NumRounds + 1;

  typedef enum logic {
    CMD_ENC = 1'b0,
    CMD_DEC = 1'b1
  } aes_cmd_e;

  typedef enum logic {
    REG_KEY_HIGH = 1'b0,
    REG_KEY_LOW  = 1'b1
  } aes_reg_e;

  typedef struct packed {
    logic        cmd;
    logic [63:0] block_high;
    logic [63:0] block_low;
  } aes_in_t;

  typedef struct packed {
    logic [63:0] result_high;
    logic [63:0] result_low;
  } aes_out_t;

  typedef logic [127:0] aes_block_t;

  // stage context travelling with the data
  typedef struct packed {
    logic       dec;
    aes_block_t state;
  } aes_stage_t;

  function automatic logic [7:0] xtime(input logic [7:0] v);
    xtime = {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] sbox(input logic [7:0] a);
    logic [7:0] t [256];
    t = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
    sbox = t[a];
  endfunction

  function automatic logic [7:0] inv_sbox(input logic [7:0] a);
    logic [7:0] t [256];
    t = '{
    8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
    8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
    8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
    8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
    8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
    8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
    8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
    8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
    8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
    8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
    8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
    8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
    8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
    8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
    8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};
    inv_sbox = t[a];
  endfunction

  function automatic logic [7:0] rcon(input logic [3:0] r);
    case (r)
      4'd0:    rcon = 8'h01;
      4'd1:    rcon = 8'h02;
      4'd2:    rcon = 8'h04;
      4'd3:    rcon = 8'h08;
      4'd4:    rcon = 8'h10;
      4'd5:    rcon = 8'h20;
      4'd6:    rcon = 8'h40;
      4'd7:    rcon = 8'h80;
      4'd8:    rcon = 8'h1b;
      4'd9:    rcon = 8'h36;
      default: rcon = 8'h00;
    endcase
  endfunction

  // byte i of a block, byte 0 in the top bits
  function automatic logic [7:0] get_byte(input aes_block_t b, input int i);
    get_byte = b[127-8*i -: 8];
  endfunction

endpackage
`default_nettype wire

// ===== rtl/aes128_block_encrypt_decrypt_top.sv =====
// Pipeline: 21 register stages (initial key add plus ten rounds split into
//   sub/shift and key/mix stages).
// Throughput: one block per cycle; the whole pipeline advances together and
//   halts while the output register holds an untaken result.
// Reset: asynchronous, active low; clears valid bits and key registers (key 0).
// Input is held off after reset and after each key write until keys settle.
`default_nettype none
module aes128_block_encrypt_decrypt_top (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_we_i,
  input  wire logic             cfg_idx_i,
  input  wire logic [63:0]      cfg_data_i,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire aes_pkg::aes_in_t in_data_i,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output aes_pkg::aes_out_t     out_data_o
);
  import aes_pkg::*;
`include "aes128_block_encrypt_decrypt_top_defines.svh"

  logic [63:0] key_high_q, key_low_q;
  aes_block_t  rk [NumRounds+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_high_q <= '0;
      key_low_q  <= '0;
    end else if (cfg_we_i) begin
      case (aes_reg_e'(cfg_idx_i))
        REG_KEY_HIGH: key_high_q <= cfg_data_i;
        REG_KEY_LOW:  key_low_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  aes_key_sched u_ks (
    .clk_i, .rst_ni, .key_i({key_high_q, key_low_q}), .rk_o(rk)
  );

  // round keys ripple one register per cycle; no block enters until the
  // last round key reflects the current key registers
  logic [3:0] settle_q, settle_d;

  always_comb begin
    if (cfg_we_i) settle_d = 4'(KeySettle);
    else if (settle_q != '0) settle_d = settle_q - 4'd1;
    else settle_d = settle_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) settle_q <= 4'(KeySettle);
    else settle_q <= settle_d;
  end

  // pipeline advances when the last stage is empty or drained
  logic       adv;
  logic       vld [NumStages+1];
  aes_stage_t stg [NumStages+1];

  assign adv        = !out_valid_o || out_ready_i;
  assign in_ready_o = adv && (settle_q == '0) && !cfg_we_i;

  // stage 0: initial AddRoundKey
  logic       vld0_q;
  aes_stage_t stg0_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld0_q <= 1'b0;
    else if (adv) vld0_q <= in_valid_i && in_ready_o;
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      stg0_q.dec   <= in_data_i.cmd;
      stg0_q.state <= {in_data_i.block_high, in_data_i.block_low} ^
                      (in_data_i.cmd == CMD_DEC ? rk[NumRounds] : rk[0]);
    end
  end
  assign vld[0] = vld0_q;
  assign stg[0] = stg0_q;

  for (genvar g = 0; g < NumStages - 1; g++) begin : g_stage
    localparam int Rnd = g / 2 + 1;
    aes_half_round u_hr (
      .clk_i, .rst_ni,
      .first_i  (1'((g % 2) == 0)),
      .mix_en_i (1'(Rnd != NumRounds)),
      .en_i     (adv),
      .vld_i    (vld[g]),
      .d_i      (stg[g]),
      .enc_key_i(rk[Rnd]),
      .dec_key_i(rk[NumRounds - Rnd]),
      .vld_o    (vld[g+1]),
      .q_o      (stg[g+1])
    );
  end

  assign vld[NumStages] = vld[NumStages-1];
  assign stg[NumStages] = stg[NumStages-1];

  assign out_valid_o            = vld[NumStages];
  assign out_data_o.result_high = stg[NumStages].state[127:64];
  assign out_data_o.result_low  = stg[NumStages].state[63:0];

  `AES_ASSERT_NXT(a_hold_out, out_valid_o && !out_ready_i,
                  out_valid_o && $stable(out_data_o))
  `AES_ASSERT_IMP(a_stall_nordy, out_valid_o && !out_ready_i, !in_ready_o)
  `AES_ASSERT_NXT(a_enter, in_valid_i && in_ready_o, vld[0])
endmodule
`default_nettype wire

// ===== rtl/aes_key_sched.sv =====
`default_nettype none
// Full key expansion, one round key per register stage; round keys are held
// until the key registers change (configuration only while idle).
module aes_key_sched (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire aes_pkg::aes_block_t  key_i,
  output aes_pkg::aes_block_t       rk_o [aes_pkg::NumRounds+1]
);
  import aes_pkg::*;

  aes_block_t rk_q [NumRounds+1];
  aes_block_t rk_d [NumRounds+1];

  always_comb begin
    logic [31:0] w0, w1, w2, w3, t;
    rk_d[0] = key_i;
    for (int r = 1; r <= NumRounds; r++) begin
      w0 = rk_q[r-1][127:96];
      w1 = rk_q[r-1][95:64];
      w2 = rk_q[r-1][63:32];
      w3 = rk_q[r-1][31:0];
      t  = {sbox(w3[23:16]) ^ rcon(4'(r-1)), sbox(w3[15:8]), sbox(w3[7:0]),
            sbox(w3[31:24])};
      w0 = w0 ^ t;
      w1 = w1 ^ w0;
      w2 = w2 ^ w1;
      w3 = w3 ^ w2;
      rk_d[r] = {w0, w1, w2, w3};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r <= NumRounds; r++) rk_q[r] <= '0;
    end else begin
      for (int r = 0; r <= NumRounds; r++) rk_q[r] <= rk_d[r];
    end
  end

  assign rk_o = rk_q;
endmodule
`default_nettype wire

// ===== rtl/aes_half_round.sv =====
`default_nettype none
// One pipeline stage. FIRST=1: sub/shift. FIRST=0: key add and mix (enc mixes
// before the key, dec after), mix skipped on the final round.
module aes_half_round (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                first_i,
  input  wire logic                mix_en_i,
  input  wire logic                en_i,
  input  wire logic                vld_i,
  input  wire aes_pkg::aes_stage_t d_i,
  input  wire aes_pkg::aes_block_t enc_key_i,
  input  wire aes_pkg::aes_block_t dec_key_i,
  output logic                     vld_o,
  output aes_pkg::aes_stage_t      q_o
);
  import aes_pkg::*;

  aes_stage_t data_d, data_q;
  logic       vld_q;

  function automatic aes_block_t mix_cols(input aes_block_t s, input logic inv);
    logic [7:0] a0, a1, a2, a3, x0, x1, x2, x3, y0, y1, y2, y3, u, v;
    aes_block_t o;
    for (int c = 0; c < 4; c++) begin
      a0 = get_byte(s, 4*c); a1 = get_byte(s, 4*c+1);
      a2 = get_byte(s, 4*c+2); a3 = get_byte(s, 4*c+3);
      if (inv) begin
        // pre-condition so the forward matrix yields the inverse
        u = xtime(xtime(a0 ^ a2));
        v = xtime(xtime(a1 ^ a3));
        a0 = a0 ^ u; a1 = a1 ^ v; a2 = a2 ^ u; a3 = a3 ^ v;
      end
      x0 = xtime(a0); x1 = xtime(a1); x2 = xtime(a2); x3 = xtime(a3);
      y0 = x0 ^ x1 ^ a1 ^ a2 ^ a3;
      y1 = a0 ^ x1 ^ x2 ^ a2 ^ a3;
      y2 = a0 ^ a1 ^ x2 ^ x3 ^ a3;
      y3 = x0 ^ a0 ^ a1 ^ a2 ^ x3;
      o[127-32*c -: 32] = {y0, y1, y2, y3};
    end
    return o;
  endfunction

  always_comb begin
    aes_block_t s, t;
    s = d_i.state;
    t = s;
    if (first_i) begin
      for (int c = 0; c < 4; c++)
        for (int r = 0; r < 4; r++)
          if (d_i.dec) t[127-8*(4*c+r) -: 8] = inv_sbox(get_byte(s, 4*((c+4-r)%4)+r));
          else t[127-8*(4*c+r) -: 8] = sbox(get_byte(s, 4*((c+r)%4)+r));
    end else if (d_i.dec) begin
      t = s ^ dec_key_i;
      if (mix_en_i) t = mix_cols(t, 1'b1);
    end else begin
      t = s;
      if (mix_en_i) t = mix_cols(t, 1'b0);
      t = t ^ enc_key_i;
    end
    data_d.dec   = d_i.dec;
    data_d.state = t;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= 1'b0;
    else if (en_i) vld_q <= vld_i;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) data_q <= data_d;
  end

  assign vld_o = vld_q;
  assign q_o   = data_q;
endmodule
`default_nettype wire
